// ===== design/md_message_padder_assert.svh =====
// Assertion helpers for the message padder, clocked on clk, reset by arst_n.
`ifndef MD_MESSAGE_PADDER_ASSERT_SVH
`define MD_MESSAGE_PADDER_ASSERT_SVH

// Same-cycle implication.
`define MDP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("md_message_padder: same-cycle check failed");

// Next-cycle implication.
`define MDP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("md_message_padder: next-cycle check failed");

`endif

// ===== design/mdp_pkg.sv =====
package mdp_pkg;

	localparam logic [7:0] PAD_MARK      = 8'h80;
	// first byte position in a block that leaves no room for the length
	localparam logic [5:0] LAST_FIT_BYTE = 6'd56;
	localparam logic [3:0] LEN_HI_WORD   = 4'd14;
	localparam logic [3:0] LAST_WORD     = 4'd15;

	typedef struct packed {
		logic [31:0] out_word;
		logic        block_last;
		logic        message_last;
	} mdp_word_t;

	typedef struct packed {
		logic      valid;
		mdp_word_t word;
	} mdp_push_t;

	function automatic logic [31:0] byte_swap32(input logic [31:0] w);
		byte_swap32 = {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

endpackage

// ===== design/mdp_word_builder.sv =====
// Byte packer and padding sequencer: one output word per cycle at most.
module mdp_word_builder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              length_little_endian,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              byte_present,
	input  logic              end_of_message,
	input  logic              space,
	output mdp_pkg::mdp_push_t push
);

	logic [63:0] byte_count_q;
	logic [23:0] partial_q;
	logic [3:0]  widx_q;
	logic        pad_q;
	logic        mark_q;
	logic        extra_q;

	logic        in_fire;
	logic        pad_step;
	logic [1:0]  k;
	logic [5:0]  pos_next;
	logic [63:0] bit_len;
	logic [31:0] mark_word;
	logic [31:0] len_word;
	logic        msg_end;

	assign in_ready = !pad_q && space;
	assign in_fire  = in_valid && in_ready;
	assign pad_step = pad_q && space;
	assign k        = byte_count_q[1:0];
	assign pos_next = byte_count_q[5:0] + {5'd0, byte_present};
	assign bit_len  = {byte_count_q[60:0], 3'b000};
	assign msg_end  = !extra_q && (widx_q == mdp_pkg::LAST_WORD);

	// word holding the remaining message bytes and the 0x80 mark
	always_comb begin
		mark_word = '0;
		if (mark_q) begin
			unique case (k)
				2'd0: mark_word = {mdp_pkg::PAD_MARK, 24'd0};
				2'd1: mark_word = {partial_q[7:0], mdp_pkg::PAD_MARK, 16'd0};
				2'd2: mark_word = {partial_q[15:0], mdp_pkg::PAD_MARK, 8'd0};
				2'd3: mark_word = {partial_q[23:0], mdp_pkg::PAD_MARK};
				default: mark_word = '0;
			endcase
		end
	end

	// length occupies the last two words of the final block
	always_comb begin
		len_word = '0;
		if (!extra_q && widx_q == mdp_pkg::LEN_HI_WORD) begin
			len_word = length_little_endian ? mdp_pkg::byte_swap32(bit_len[31:0])
			                                : bit_len[63:32];
		end else if (!extra_q && widx_q == mdp_pkg::LAST_WORD) begin
			len_word = length_little_endian ? mdp_pkg::byte_swap32(bit_len[63:32])
			                                : bit_len[31:0];
		end
	end

	always_comb begin
		push = '0;
		if (in_fire && byte_present && k == 2'd3) begin
			push.valid             = 1'b1;
			push.word.out_word     = {partial_q, data_byte};
			push.word.block_last   = (widx_q == mdp_pkg::LAST_WORD);
			push.word.message_last = 1'b0;
		end else if (pad_step) begin
			push.valid             = 1'b1;
			push.word.out_word     = mark_word | len_word;
			push.word.block_last   = (widx_q == mdp_pkg::LAST_WORD);
			push.word.message_last = msg_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			partial_q    <= '0;
			widx_q       <= '0;
			pad_q        <= 1'b0;
			mark_q       <= 1'b0;
			extra_q      <= 1'b0;
		end else if (in_fire) begin
			if (byte_present) begin
				byte_count_q <= byte_count_q + 64'd1;
				if (k == 2'd3) begin
					partial_q <= '0;
					widx_q    <= widx_q + 4'd1;
				end else begin
					partial_q <= {partial_q[15:0], data_byte};
				end
			end
			if (end_of_message) begin
				pad_q   <= 1'b1;
				mark_q  <= 1'b1;
				extra_q <= (pos_next >= mdp_pkg::LAST_FIT_BYTE);
			end
		end else if (pad_step) begin
			mark_q <= 1'b0;
			widx_q <= widx_q + 4'd1;
			if (widx_q == mdp_pkg::LAST_WORD) begin
				extra_q <= 1'b0;
			end
			if (msg_end) begin
				pad_q        <= 1'b0;
				byte_count_q <= '0;
				partial_q    <= '0;
				widx_q       <= '0;
			end
		end
	end

endmodule

// ===== design/mdp_out_queue.sv =====
// Output register plus skid register; takes one more word while the head is stalled.
module mdp_out_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  mdp_pkg::mdp_push_t push,
	output logic               space,
	output logic               out_valid,
	input  logic               out_ready,
	output mdp_pkg::mdp_word_t head
);

	mdp_pkg::mdp_word_t main_q;
	mdp_pkg::mdp_word_t skid_q;
	logic               main_v_q;
	logic               skid_v_q;
	logic               pop;

	assign space     = !skid_v_q;
	assign out_valid = main_v_q;
	assign head      = main_q;
	assign pop       = main_v_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (!main_v_q || pop) begin
			main_v_q <= push.valid;
		end else if (push.valid) begin
			skid_v_q <= 1'b1;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (!main_v_q || pop) begin
			if (push.valid) begin
				main_q <= push.word;
			end
		end else if (push.valid) begin
			skid_q <= push.word;
		end
	end

endmodule

// ===== design/md_message_padder.sv =====
// MD5 / SHA-256 message padder.
// Input channel (in_valid/in_ready): one item per message byte; byte_present
// says data_byte is real, end_of_message closes the message (it may come with
// or without a byte). Output channel (out_valid/out_ready): 32-bit words,
// earliest byte in bits 31..24, block_last on word 16 of each 64-byte block,
// message_last on the final length word.
// cfg_write_en/cfg_write_data set the length byte order (1 = little-endian,
// MD5). Change it only between messages.
// A word completed by an item is registered in the output queue before it is
// presented. The packer takes one item per cycle while in_ready is high.
// After end_of_message the padding sequencer emits one word per cycle while the
// queue has space, 3 to 18 words, and in_ready stays low until the last one.
// A two-entry output queue (output register plus skid) holds a second word
// while the head word waits; if the receiver keeps stalling, in_ready
// drops once the skid entry is taken.
// Reset clears counters, queue valid flags and register (big-endian); no clearing pass.
module md_message_padder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic        cfg_write_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_word,
	output logic        block_last,
	output logic        message_last
);

	`include "md_message_padder_assert.svh"

	logic               length_le_q;
	logic               space;
	mdp_pkg::mdp_push_t push;
	mdp_pkg::mdp_word_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_le_q <= 1'b0;
		end else if (cfg_write_en) begin
			length_le_q <= cfg_write_data;
		end
	end

	// packing and padding, feeds the queue one word per cycle at most
	mdp_word_builder u_builder (
		.clk                  (clk),
		.arst_n               (arst_n),
		.length_little_endian (length_le_q),
		.in_valid             (in_valid),
		.in_ready             (in_ready),
		.data_byte            (data_byte),
		.byte_present         (byte_present),
		.end_of_message       (end_of_message),
		.space                (space),
		.push                 (push)
	);

	mdp_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign out_word     = head.out_word;
	assign block_last   = head.block_last;
	assign message_last = head.message_last;

	// the final word always closes a block
	`MDP_ASSERT_IMP(a_msg_last_closes_block, out_valid && message_last, block_last)
	// padding holds the input off right after the message ends
	`MDP_ASSERT_NEXT(a_pad_blocks_input, in_valid && in_ready && end_of_message, !in_ready)
	// input is never taken while the skid entry is occupied
	`MDP_ASSERT_IMP(a_ready_needs_space, in_ready, space)

endmodule
